@@ src/ach_pkg.sv @@
// Package for the ARX checkerboard 64-bit hash: constants, command and op types,
// and the small helper functions shared by the front, back and top level.
// No dependencies.
package ach_pkg;

  // Width of a message length and the number of length bits that are honored.
  localparam int LenW    = 32;
  localparam int LenBits = 32;
  localparam logic [LenW-1:0] LenMask =
    (LenBits >= LenW) ? {LenW{1'b1}} : LenW'((64'd1 << LenBits) - 64'd1);

  // Depth of the queue between front and back.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Multiplier constants.
  localparam logic [63:0] K0 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] K1 = 64'h85EBCA77C2B2AE3D;
  localparam logic [63:0] K2 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] K3 = 64'h94D049BB133111EB;

  // Finalizer shift amounts.
  localparam int FinShift0 = 29;
  localparam int FinShift1 = 31;
  localparam int FinShift2 = 37;
  localparam int FinShift3 = 41;

  // Command codes on the input word.
  localparam logic CmdStart = 1'b0;
  localparam logic CmdData  = 1'b1;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_STRIPE,
    KIND_FOLD
  } op_kind_e;

  // One classified operation handed from front to back.
  typedef struct packed {
    op_kind_e        kind;
    logic            last;
    logic [1:0]      idx;
    logic [LenW-1:0] len;
    logic [63:0]     word;
  } op_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] n);
    logic [63:0] r;
    if (n == 6'd0) begin
      r = v;
    end else begin
      r = (v << n) | (v >> (7'd64 - {1'b0, n}));
    end
    return r;
  endfunction

  // Rotation amount of one step of the add-rotate chain.
  function automatic logic [5:0] rot_amt(input logic odd, input logic [1:0] idx);
    logic [5:0] r;
    case (idx)
      2'd0:    r = odd ? 6'd13 : 6'd11;
      2'd1:    r = odd ? 6'd31 : 6'd17;
      2'd2:    r = odd ? 6'd43 : 6'd23;
      default: r = odd ? 6'd59 : 6'd57;
    endcase
    return r;
  endfunction

  // Constant that seeds each lane from the base value.
  function automatic logic [63:0] lane_k(input logic [1:0] idx);
    logic [63:0] k;
    case (idx)
      2'd0:    k = K0;
      2'd1:    k = K1;
      2'd2:    k = K2;
      default: k = K3;
    endcase
    return k;
  endfunction

endpackage

@@ src/ach_front.sv @@
// Front end of the hash: accepts input words, tracks the open message and its
// remaining length, and turns each word into an op for the back end.
// Depends on ach_pkg.
module ach_front import ach_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             cmd_i,
  input  logic [63:0]      seed_i,
  input  logic [LenW-1:0]  message_length_i,
  input  logic [63:0]      data_word_i,
  input  logic             q_full_i,
  output logic             enq_o,
  output op_t              op_o
);

  logic            open_q, open_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [1:0]      wis_q, wis_d;
  logic            accept;
  logic [LenW-1:0] len_m;
  logic [63:0]     byte_mask;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign len_m  = message_length_i & LenMask;

  // Keep only the bytes below the remaining count in a part word.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[8*i +: 8] = (3'(i) < rem_q[2:0]) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    open_d      = open_q;
    rem_d       = rem_q;
    wis_d       = wis_q;
    enq_o       = 1'b0;
    op_o        = '0;
    op_o.kind   = KIND_FOLD;
    op_o.idx    = wis_q;
    op_o.word   = data_word_i;
    if (accept) begin
      if (cmd_i == CmdStart) begin
        enq_o     = 1'b1;
        op_o.kind = KIND_START;
        op_o.word = seed_i;
        op_o.len  = len_m;
        op_o.last = (len_m == '0);
        rem_d     = len_m;
        wis_d     = 2'd0;
        open_d    = (len_m != '0);
      end else if (open_q) begin
        enq_o = 1'b1;
        if ((wis_q != 2'd0) || (|rem_q[LenW-1:5])) begin
          op_o.kind = KIND_STRIPE;
          rem_d     = rem_q - LenW'(8);
          wis_d     = wis_q + 2'd1;
        end else begin
          op_o.kind = KIND_FOLD;
          if (|rem_q[LenW-1:3]) begin
            rem_d = rem_q - LenW'(8);
          end else begin
            op_o.word = data_word_i & byte_mask;
            rem_d     = '0;
          end
        end
        op_o.last = (rem_d == '0);
        open_d    = (rem_d != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= '0;
      wis_q  <= 2'd0;
    end else begin
      open_q <= open_d;
      rem_q  <= rem_d;
      wis_q  <= wis_d;
    end
  end

endmodule

@@ src/ach_fifo.sv @@
// Short queue of ops between the front and the back of the hash.
// Depends on ach_pkg for the op type and the queue depth.
module ach_fifo import ach_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic enq_i,
  input  op_t  data_i,
  input  logic deq_i,
  output logic full_o,
  output logic empty_o,
  output op_t  data_o
);

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_enq, do_deq;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_enq  = enq_i && !full_o;
  assign do_deq  = deq_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_enq) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_deq) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      case ({do_enq, do_deq})
        2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/ach_mul.sv @@
// Multiply unit: the low 64 bits of a 64-bit value times a 64-bit constant,
// built from one registered 32x32 multiplier over four steps. Depends on ach_pkg.
module ach_mul import ach_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] k_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0] a_q, k_q, prod_q, acc_q;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] mx, my;

  // Step 0: low x low, step 1: low x high, step 2: high x low.
  assign mx = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign my = (step_q == 2'd1) ? k_q[63:32] : k_q[31:0];

  assign done_o = done_q;
  assign p_o    = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      k_q <= k_i;
    end
    if (busy_q) begin
      prod_q <= 64'(mx * my);
      case (step_q)
        2'd1:    acc_q <= prod_q;
        2'd2:    acc_q <= acc_q + {prod_q[31:0], 32'd0};
        2'd3:    acc_q <= acc_q + {prod_q[31:0], 32'd0};
        default: acc_q <= acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

@@ src/ach_back.sv @@
// Back end of the hash: holds the four lanes, runs the stripe and fold updates,
// the seed setup and the finalizer, and keeps the result register.
// Depends on ach_pkg and ach_mul.
module ach_back import ach_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  op_t         op_i,
  output logic        deq_o,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] hash_value_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHAIN = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_LANE  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_FMUL  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        parity_q, parity_d;
  logic        last_q, last_d;
  logic        ovalid_q, ovalid_d;
  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic [63:0] seed_q, seed_d;
  logic [63:0] base_q, base_d;
  logic [63:0] res_q, res_d;
  logic [63:0] hash_q, hash_d;
  logic [63:0] fin_h;
  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_k, mul_p;

  ach_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .k_i     (mul_k),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign empty        = !ovalid_q;
  assign hash_value_o = hash_q;
  assign fin_h        = lane_q[0] ^ lane_q[1] ^ lane_q[2] ^ lane_q[3];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    parity_d  = parity_q;
    last_d    = last_q;
    ovalid_d  = ovalid_q;
    lane_d    = lane_q;
    seed_d    = seed_q;
    base_d    = base_q;
    res_d     = res_q;
    hash_d    = hash_q;
    deq_o     = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_k     = '0;
    if (pop && ovalid_q) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          deq_o  = 1'b1;
          last_d = op_i.last;
          case (op_i.kind)
            KIND_START: begin
              parity_d  = 1'b0;
              seed_d    = op_i.word;
              mul_start = 1'b1;
              mul_a     = {{(64-LenW){1'b0}}, op_i.len};
              mul_k     = K0;
              state_d   = S_LEN;
            end
            KIND_STRIPE: begin
              lane_d[op_i.idx] = lane_q[op_i.idx] ^ op_i.word;
              if (op_i.idx == 2'd3) begin
                // First half of the chain; lane four finishes next cycle.
                lane_d[0] = rotl64(lane_q[0] + lane_q[1], rot_amt(parity_q, 2'd0));
                lane_d[1] = rotl64(lane_q[1] + lane_q[2], rot_amt(parity_q, 2'd1));
                lane_d[2] = rotl64(lane_q[2] + (lane_q[3] ^ op_i.word),
                                   rot_amt(parity_q, 2'd2));
                state_d   = S_CHAIN;
              end else if (op_i.last) begin
                state_d = S_FIN;
              end
            end
            KIND_FOLD: begin
              lane_d[0] = rotl64((lane_q[0] ^ op_i.word) + lane_q[1],
                                 rot_amt(parity_q, 2'd0));
              parity_d  = !parity_q;
              if (op_i.last) begin
                state_d = S_FIN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CHAIN: begin
        lane_d[3] = rotl64(lane_q[3] + lane_q[0], rot_amt(parity_q, 2'd3));
        parity_d  = !parity_q;
        state_d   = last_q ? S_FIN : S_IDLE;
      end
      S_LEN: begin
        if (mul_done) begin
          base_d    = seed_q ^ mul_p;
          mul_start = 1'b1;
          mul_a     = seed_q ^ mul_p;
          mul_k     = K0;
          cnt_d     = 2'd0;
          state_d   = S_LANE;
        end
      end
      S_LANE: begin
        if (mul_done) begin
          lane_d[cnt_q] = mul_p;
          if (cnt_q == 2'd3) begin
            state_d = last_q ? S_FIN : S_IDLE;
          end else begin
            cnt_d     = cnt_q + 2'd1;
            mul_start = 1'b1;
            mul_a     = base_q;
            mul_k     = lane_k(cnt_q + 2'd1);
          end
        end
      end
      S_FIN: begin
        mul_start = 1'b1;
        mul_a     = fin_h ^ (fin_h >> FinShift0);
        mul_k     = K1;
        cnt_d     = 2'd0;
        state_d   = S_FMUL;
      end
      S_FMUL: begin
        if (mul_done) begin
          if (cnt_q == 2'd2) begin
            res_d   = mul_p ^ (mul_p >> FinShift3);
            state_d = S_OUT;
          end else begin
            mul_start = 1'b1;
            mul_a     = (cnt_q == 2'd0) ? (mul_p ^ (mul_p >> FinShift1))
                                        : (mul_p ^ (mul_p >> FinShift2));
            mul_k     = (cnt_q == 2'd0) ? K2 : K0;
            cnt_d     = cnt_q + 2'd1;
          end
        end
      end
      S_OUT: begin
        if (!ovalid_q || pop) begin
          hash_d   = res_q;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    seed_d_unused_guard: begin
      seed_q <= seed_d;
      base_q <= base_d;
      res_q  <= res_d;
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= 2'd0;
      parity_q <= 1'b0;
      last_q   <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lane_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      parity_q <= parity_d;
      last_q   <= last_d;
      ovalid_q <= ovalid_d;
      lane_q   <= lane_d;
    end
  end

endmodule

@@ src/arx_checkerboard_hash64_top.sv @@
// Top level of the ARX checkerboard 64-bit hash.
// Depends on ach_pkg, ach_front, ach_fifo and ach_back (which holds ach_mul).
//
// The block hashes a stream of messages and looks like a queue on both sides.
// A start word (cmd_i low) carries the seed and the message length in bytes;
// data words (cmd_i high) then bring the message eight bytes at a time, first
// byte in bits 7:0, and bytes past the length in the last word are ignored.
// Exactly one hash_value_o word comes out per message, after its last byte,
// or straight from the start word when the length is zero. A data word while
// no message is open is dropped. A start word while a message is open drops
// that message. The front end classifies each word and keeps the length
// count; a four-entry queue separates it from the back end, which owns the
// four lanes, so input words keep flowing until that queue fills while the
// back end is busy with multiplies or while a finished hash waits to be
// popped. Each data word is applied in the back end's idle state, except the
// fourth word of every 32-byte stripe, which also passes through a chain
// state for the full add-rotate chain. All 64-bit products come from one
// shared 32x32 multiplier, one product at a time: a start word therefore
// needs a length product plus four lane products, and the finalizer three
// products before it loads the result register.
module arx_checkerboard_hash64_top import ach_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             cmd_i,
  input  logic [63:0]      seed_i,
  input  logic [LenW-1:0]  message_length_i,
  input  logic [63:0]      data_word_i,
  output logic             empty,
  input  logic             pop,
  output logic [63:0]      hash_value_o
);

  op_t  fr_op, bk_op;
  logic fr_enq, q_full, q_empty, bk_deq;

  // Front end: classification and length bookkeeping.
  ach_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .cmd_i            (cmd_i),
    .seed_i           (seed_i),
    .message_length_i (message_length_i),
    .data_word_i      (data_word_i),
    .q_full_i         (q_full),
    .enq_o            (fr_enq),
    .op_o             (fr_op)
  );

  // Op queue between the two halves.
  ach_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (fr_enq),
    .data_i  (fr_op),
    .deq_i   (bk_deq),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (bk_op)
  );

  // Back end: lane updates, seed setup, finalizer and result register.
  ach_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .op_i         (bk_op),
    .deq_o        (bk_deq),
    .empty        (empty),
    .pop          (pop),
    .hash_value_o (hash_value_o)
  );

endmodule

@@ src/ach_checker.sv @@
// Port-level checks on the ARX checkerboard hash top level, and the bind that
// attaches them. Depends on arx_checkerboard_hash64_top.
module ach_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [63:0] hash_value_o
);

  // Once reset has been seen low, no result waits and the input side is open.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("reset state shows a result or a full input side");

  // A waiting result that is not popped stays and keeps its value.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(hash_value_o))
    else $error("waiting result changed or vanished without a pop");

  // The queue can only fill up right after an accepted word.
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a word being pushed");

  // The result side can only drain through a pop.
  a_empty_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result disappeared without a pop");

endmodule

bind arx_checkerboard_hash64_top ach_checker u_checker (.*);
